// ===== design/dece_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dece_pkg
// Shared types and constants of the directed Euler circuit engine.
// ----------------------------------------------------------------------------
package dece_pkg;

  localparam int unsigned ROW_W  = 32;    // adjacency row width
  localparam int unsigned VID_W  = 5;     // vertex id width
  localparam int unsigned LEN_W  = 11;    // list length / pointer width
  localparam int unsigned CNT_W  = 6;     // vertex count register width
  localparam int unsigned LIST_D = 1025;  // stack and list depth
  localparam logic [LEN_W-1:0] LIST_DEPTH = 11'd1025;

  localparam logic [1:0] MODE_LOAD     = 2'd0;
  localparam logic [1:0] MODE_CLASSIFY = 2'd1;
  localparam logic [1:0] MODE_BUILD    = 2'd2;
  localparam logic [1:0] MODE_READ     = 2'd3;

  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_CIRCUIT = 2'd1;
  localparam logic [1:0] VERDICT_PATH    = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [VID_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
    logic [VID_W-1:0] start_vertex;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       verdict;
    logic [VID_W-1:0] vertex;
    logic [LEN_W-1:0] circuit_length;
    logic             last;
    logic             none_left;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_C_RD,
    S_C_DEG,
    S_C_ROOT,
    S_C_CRD,
    S_C_CUSE,
    S_C_BAL,
    S_B_CRD,
    S_B_CWR,
    S_W_RD,
    S_W_DEC,
    S_W_POP,
    S_R_RD,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== design/directed_euler_circuit_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// directed_euler_circuit_engine
// Holds a directed graph as adjacency rows, classifies it as Euler circuit,
// Euler path or neither, builds a Hierholzer circuit and reads it back.
// ----------------------------------------------------------------------------
// throughput: one item at a time; the adjacency, work, stack and list RAMs
//   each have one read port, so every row or stack access waits for the
//   registered read data of its RAM
// reset: synchronous active low; clears control, row valid bits, circuit
//   length and read pointer; vertex count returns to 32; no clearing pass
// ----------------------------------------------------------------------------
module directed_euler_circuit_engine #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire dece_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output dece_pkg::out_item_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [5:0]           cfg_data
);
  import dece_pkg::*;

  // usable vertex limit and derived widths
  localparam int unsigned VLIM = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int unsigned AW   = $clog2(VLIM);      // row address width
  localparam int unsigned CW   = $clog2(VLIM + 1);  // loop counter width
  localparam int unsigned DW   = $clog2(VLIM + 1);  // degree width

  function automatic logic [5:0] popcnt(input logic [ROW_W-1:0] x);
    logic [5:0] c;
    c = '0;
    for (int b = 0; b < ROW_W; b++) begin
      c = c + 6'(x[b]);
    end
    return c;
  endfunction

  function automatic logic [VID_W-1:0] low_bit(input logic [ROW_W-1:0] x);
    logic [VID_W-1:0] p;
    p = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (x[b]) p = VID_W'(b);
    end
    return p;
  endfunction

  // control and datapath registers
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  vc_r;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [VLIM-1:0]   reach_r, reach_nxt;
  logic [VLIM-1:0]   vis_r, vis_nxt;
  logic              chg_r, chg_nxt;
  logic              roots_r, roots_nxt;
  logic [1:0]        mo_r, mo_nxt, mi_r, mi_nxt;
  logic              bad_r, bad_nxt;
  logic [DW-1:0]     outd_r [VLIM];
  logic [DW-1:0]     outd_nxt [VLIM];
  logic [DW-1:0]     ind_r [VLIM];
  logic [DW-1:0]     ind_nxt [VLIM];
  logic [LEN_W-1:0]  sp_r, sp_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [VID_W-1:0]  top_r, top_nxt;
  logic [VID_W-1:0]  start_r, start_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  rp_r, rp_nxt;
  logic [VLIM-1:0]   adj_vld_r;
  logic              vld_q_r;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  // ram ports
  logic              adj_we;
  logic [ROW_W-1:0]  adj_q;
  logic              work_we;
  logic [ROW_W-1:0]  work_wdata, work_q;
  logic              stk_we;
  logic [LEN_W-1:0]  stk_waddr;
  logic [VID_W-1:0]  stk_wdata, stk_q;
  logic              lst_we;
  logic [VID_W-1:0]  lst_q;

  logic              accept;
  logic              out_free;
  logic [CW-1:0]     n_w;
  logic [ROW_W-1:0]  mask_w;
  logic [ROW_W-1:0]  row_d;
  logic [ROW_W-1:0]  work_r_d;
  logic              top_ok;
  logic              can_push;
  logic [DW:0]       od_w, id_w;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // used vertex count: 0 acts as 1, anything above the limit acts as the limit
  always_comb begin
    if (vc_r == '0) begin
      n_w = CW'(1);
    end else if (32'(vc_r) > VLIM) begin
      n_w = CW'(VLIM);
    end else begin
      n_w = CW'(vc_r);
    end
    for (int j = 0; j < ROW_W; j++) begin
      mask_w[j] = (32'(j) < 32'(n_w));
    end
  end

  // row read back, unwritten rows read as zero
  assign row_d    = vld_q_r ? (adj_q & mask_w) : '0;
  assign top_ok   = (32'(top_r) < VLIM);
  assign work_r_d = top_ok ? work_q : '0;
  assign can_push = (work_r_d != '0) && (sp_r < LIST_DEPTH);
  assign od_w     = (DW + 1)'(outd_r[i_r[AW-1:0]]);
  assign id_w     = (DW + 1)'(ind_r[i_r[AW-1:0]]);

  // ram instances
  dece_ram #(.WIDTH(ROW_W), .DEPTH(VLIM)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (in_data.row_index[AW-1:0]),
    .wdata (in_data.row_bits),
    .raddr (k_r[AW-1:0]),
    .rdata (adj_q)
  );

  // working copy of the matrix, edges removed as the walk takes them
  dece_ram #(.WIDTH(ROW_W), .DEPTH(VLIM)) u_work (
    .clk   (clk),
    .we    (work_we),
    .waddr ((state_r == S_B_CWR) ? k_r[AW-1:0] : top_r[AW-1:0]),
    .wdata (work_wdata),
    .raddr (top_r[AW-1:0]),
    .rdata (work_q)
  );

  // walk stack, top kept in top_r, element below it read on pop
  dece_ram #(.WIDTH(VID_W), .DEPTH(LIST_D)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (sp_r - LEN_W'(2)),
    .rdata (stk_q)
  );

  // pop order list, read backwards to give the circuit in walk order
  dece_ram #(.WIDTH(VID_W), .DEPTH(LIST_D)) u_list (
    .clk   (clk),
    .we    (lst_we),
    .waddr (cnt_r),
    .wdata (top_r),
    .raddr (count_r - LEN_W'(1) - rp_r),
    .rdata (lst_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.mode)
            MODE_CLASSIFY: state_nxt = S_C_RD;
            MODE_BUILD:    state_nxt = S_B_CRD;
            MODE_READ:     state_nxt = (rp_r < count_r) ? S_R_RD : S_IDLE;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_C_RD:   state_nxt = (k_r == n_w) ? S_C_ROOT : S_C_DEG;
      S_C_DEG:  state_nxt = S_C_RD;
      S_C_ROOT: begin
        if (i_r == n_w) begin
          state_nxt = S_C_BAL;
        end else if (!vis_r[i_r[AW-1:0]] &&
                     ((outd_r[i_r[AW-1:0]] != '0) || (ind_r[i_r[AW-1:0]] != '0))) begin
          state_nxt = roots_r ? S_FIN : S_C_CRD;
        end
      end
      S_C_CRD: begin
        if (k_r == n_w) begin
          state_nxt = chg_r ? S_C_CRD : S_C_ROOT;
        end else begin
          state_nxt = S_C_CUSE;
        end
      end
      S_C_CUSE: state_nxt = S_C_CRD;
      S_C_BAL:  state_nxt = (i_r == n_w) ? S_FIN : S_C_BAL;
      S_B_CRD:  state_nxt = (32'(k_r) == VLIM) ? S_W_RD : S_B_CWR;
      S_B_CWR:  state_nxt = S_B_CRD;
      S_W_RD:   state_nxt = S_W_DEC;
      S_W_DEC: begin
        if (can_push) begin
          state_nxt = S_W_RD;
        end else begin
          state_nxt = (sp_r == LEN_W'(1)) ? S_FIN : S_W_POP;
        end
      end
      S_W_POP:  state_nxt = S_W_RD;
      S_R_RD:   state_nxt = S_FIN;
      S_FIN:    state_nxt = out_free ? S_IDLE : S_FIN;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram controls
  always_comb begin
    k_nxt         = k_r;
    i_nxt         = i_r;
    reach_nxt     = reach_r;
    vis_nxt       = vis_r;
    chg_nxt       = chg_r;
    roots_nxt     = roots_r;
    mo_nxt        = mo_r;
    mi_nxt        = mi_r;
    bad_nxt       = bad_r;
    outd_nxt      = outd_r;
    ind_nxt       = ind_r;
    sp_nxt        = sp_r;
    cnt_nxt       = cnt_r;
    top_nxt       = top_r;
    start_nxt     = start_r;
    count_nxt     = count_r;
    rp_nxt        = rp_r;
    res_nxt       = res_r;
    adj_we        = 1'b0;
    work_we       = 1'b0;
    work_wdata    = '0;
    stk_we        = 1'b0;
    stk_waddr     = sp_r;
    stk_wdata     = '0;
    lst_we        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          k_nxt   = '0;
          unique case (in_data.mode)
            MODE_LOAD: begin
              adj_we              = (32'(in_data.row_index) < VLIM);
              out_valid_nxt       = 1'b1;
              out_nxt             = '0;
              out_nxt.circuit_length = count_r;
            end
            MODE_CLASSIFY: begin
              for (int j = 0; j < VLIM; j++) begin
                ind_nxt[j] = '0;
              end
            end
            MODE_BUILD: begin
              start_nxt = in_data.start_vertex;
            end
            default: begin
              // read: list entry is fetched this cycle, empty read answers now
              if (!(rp_r < count_r)) begin
                out_valid_nxt          = 1'b1;
                out_nxt                = '0;
                out_nxt.circuit_length = count_r;
                out_nxt.none_left      = 1'b1;
              end
            end
          endcase
        end
      end

      // degree sweep
      S_C_RD: begin
        if (k_r == n_w) begin
          i_nxt     = '0;
          vis_nxt   = '0;
          roots_nxt = 1'b0;
        end
      end
      S_C_DEG: begin
        outd_nxt[k_r[AW-1:0]] = DW'(popcnt(row_d));
        for (int j = 0; j < VLIM; j++) begin
          ind_nxt[j] = ind_r[j] + DW'(row_d[j]);
        end
        k_nxt = k_r + CW'(1);
      end

      // root count, one closure per new root
      S_C_ROOT: begin
        if (i_r == n_w) begin
          i_nxt   = '0;
          mo_nxt  = '0;
          mi_nxt  = '0;
          bad_nxt = 1'b0;
        end else if (!vis_r[i_r[AW-1:0]] &&
                     ((outd_r[i_r[AW-1:0]] != '0) || (ind_r[i_r[AW-1:0]] != '0))) begin
          if (roots_r) begin
            // second root: not connected
            res_nxt.verdict = VERDICT_NONE;
          end else begin
            roots_nxt              = 1'b1;
            reach_nxt              = '0;
            reach_nxt[i_r[AW-1:0]] = 1'b1;
            k_nxt                  = '0;
            chg_nxt                = 1'b0;
          end
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      S_C_CRD: begin
        if (k_r == n_w) begin
          k_nxt   = '0;
          chg_nxt = 1'b0;
          if (!chg_r) begin
            vis_nxt = vis_r | reach_r;
            i_nxt   = i_r + CW'(1);
          end
        end
      end
      S_C_CUSE: begin
        if (reach_r[k_r[AW-1:0]]) begin
          reach_nxt = reach_r | row_d[VLIM-1:0];
          chg_nxt   = chg_r || ((reach_r | row_d[VLIM-1:0]) != reach_r);
        end
        k_nxt = k_r + CW'(1);
      end

      // degree balance
      S_C_BAL: begin
        if (i_r == n_w) begin
          if ((mo_r == 2'd0) && (mi_r == 2'd0) && !bad_r) begin
            res_nxt.verdict = VERDICT_CIRCUIT;
          end else if ((mo_r == 2'd1) && (mi_r == 2'd1) && !bad_r) begin
            res_nxt.verdict = VERDICT_PATH;
          end else begin
            res_nxt.verdict = VERDICT_NONE;
          end
        end else begin
          if (od_w == id_w) begin
            bad_nxt = bad_r;
          end else if (od_w == id_w + (DW + 1)'(1)) begin
            mo_nxt = (mo_r == 2'd2) ? mo_r : mo_r + 2'd1;
          end else if (id_w == od_w + (DW + 1)'(1)) begin
            mi_nxt = (mi_r == 2'd2) ? mi_r : mi_r + 2'd1;
          end else begin
            bad_nxt = 1'b1;
          end
          i_nxt = i_r + CW'(1);
        end
      end

      // working copy fill, then first stack entry
      S_B_CRD: begin
        if (32'(k_r) == VLIM) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = start_r;
          sp_nxt    = LEN_W'(1);
          cnt_nxt   = '0;
          top_nxt   = start_r;
        end
      end
      S_B_CWR: begin
        work_we    = 1'b1;
        work_wdata = (k_r < n_w) ? row_d : '0;
        k_nxt      = k_r + CW'(1);
      end

      // stack walk: take lowest remaining edge or pop to the list
      S_W_DEC: begin
        if (can_push) begin
          work_we    = 1'b1;
          work_wdata = work_r_d & ~(ROW_W'(1) << low_bit(work_r_d));
          stk_we     = 1'b1;
          stk_waddr  = sp_r;
          stk_wdata  = low_bit(work_r_d);
          sp_nxt     = sp_r + LEN_W'(1);
          top_nxt    = low_bit(work_r_d);
        end else begin
          if (cnt_r < LIST_DEPTH) begin
            lst_we  = 1'b1;
            cnt_nxt = cnt_r + LEN_W'(1);
          end
          sp_nxt = sp_r - LEN_W'(1);
          if (sp_r == LEN_W'(1)) begin
            count_nxt = (cnt_r < LIST_DEPTH) ? cnt_r + LEN_W'(1) : cnt_r;
            rp_nxt    = '0;
          end
        end
      end
      S_W_POP: begin
        top_nxt = stk_q;
      end

      S_R_RD: begin
        res_nxt.vertex = lst_q;
        res_nxt.last   = (rp_r + LEN_W'(1) == count_r);
        rp_nxt         = rp_r + LEN_W'(1);
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt                = res_r;
          out_nxt.circuit_length = count_r;
        end
      end

      default: begin
        out_nxt = out_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= CNT_W'(32);
      count_r     <= '0;
      rp_r        <= '0;
      adj_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vc_r <= cfg_data;
      end
      if (adj_we) begin
        adj_vld_r[in_data.row_index[AW-1:0]] <= 1'b1;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    i_r     <= i_nxt;
    reach_r <= reach_nxt;
    vis_r   <= vis_nxt;
    chg_r   <= chg_nxt;
    roots_r <= roots_nxt;
    mo_r    <= mo_nxt;
    mi_r    <= mi_nxt;
    bad_r   <= bad_nxt;
    outd_r  <= outd_nxt;
    ind_r   <= ind_nxt;
    sp_r    <= sp_nxt;
    cnt_r   <= cnt_nxt;
    top_r   <= top_nxt;
    start_r <= start_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
    vld_q_r <= adj_vld_r[k_r[AW-1:0]];
  end

endmodule
`default_nettype wire

// ===== design/dece_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dece_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dece_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== verif/dece_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dece_checker
// Watches the item, result and register channels of the Euler circuit engine,
// keeps its own copy of the graph and the stored circuit, predicts every
// result and compares it field by field in order of arrival.
// ----------------------------------------------------------------------------
module dece_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire dece_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire dece_pkg::out_item_t out_data,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [5:0]          cfg_data,
  output int                       fail_count,
  output int                       pending,
  output int                       checked
);
  import dece_pkg::*;

  logic [31:0] graph_rows [32];
  logic [4:0]  walk_list [LIST_D];
  int unsigned walk_len;
  int unsigned read_pos;
  logic [5:0]  vcount;
  out_item_t   awaited [$];
  int          fails;
  int          seen;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    fails      = 0;
    seen       = 0;
  end

  function automatic int unsigned used_vertices();
    if (vcount == 0) return 1;
    if (vcount > 32) return 32;
    return vcount;
  endfunction

  function automatic logic [31:0] column_mask(int unsigned n);
    if (n >= 32) return '1;
    return (32'd1 << n) - 1;
  endfunction

  function automatic logic [1:0] classify_graph();
    int unsigned n;
    logic [31:0] m, r, reach, prev, nxt, marks;
    int od [32];
    int id [32];
    int roots, more_out, more_in, bad;
    n = used_vertices();
    m = column_mask(n);
    roots = 0; more_out = 0; more_in = 0; bad = 0;
    for (int i = 0; i < 32; i++) begin
      od[i] = 0;
      id[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      r = graph_rows[i] & m;
      od[i] = $countones(r);
      for (int j = 0; j < n; j++) if (r[j]) id[j]++;
    end
    // one root per group reached along edges from it, in index order
    marks = '0;
    for (int i = 0; i < n; i++) begin
      if (!marks[i] && (od[i] > 0 || id[i] > 0)) begin
        roots++;
        reach = 32'd1 << i;
        prev = '0;
        while (reach != prev) begin
          prev = reach;
          nxt = reach;
          for (int k = 0; k < n; k++) if (reach[k]) nxt |= graph_rows[k] & m;
          reach = nxt;
        end
        marks |= reach;
      end
    end
    if (roots > 1) return VERDICT_NONE;
    for (int i = 0; i < n; i++) begin
      if (od[i] == id[i]) continue;
      if (od[i] == id[i] + 1) more_out++;
      else if (id[i] == od[i] + 1) more_in++;
      else bad++;
    end
    if (more_out == 0 && more_in == 0 && bad == 0) return VERDICT_CIRCUIT;
    if (more_out == 1 && more_in == 1 && bad == 0) return VERDICT_PATH;
    return VERDICT_NONE;
  endfunction

  function automatic void build_circuit(logic [4:0] origin);
    int unsigned n;
    logic [31:0] m;
    logic [31:0] spare [32];
    logic [4:0]  stk [LIST_D];
    logic [4:0]  popped [LIST_D];
    logic [4:0]  top_v;
    int unsigned sp, cnt;
    int b;
    n = used_vertices();
    m = column_mask(n);
    for (int i = 0; i < 32; i++) spare[i] = (i < n) ? (graph_rows[i] & m) : '0;
    sp = 0;
    cnt = 0;
    stk[sp] = origin;
    sp++;
    while (sp > 0) begin
      top_v = stk[sp - 1];
      if (spare[top_v] != 0 && sp < LIST_D) begin
        b = 0;
        while (!spare[top_v][b]) b++;
        spare[top_v][b] = 1'b0;
        stk[sp] = b[4:0];
        sp++;
      end else begin
        sp--;
        if (cnt < LIST_D) begin
          popped[cnt] = top_v;
          cnt++;
        end
      end
    end
    walk_len = cnt;
    for (int i = 0; i < walk_len; i++) walk_list[i] = popped[walk_len - 1 - i];
    read_pos = 0;
  endfunction

  function automatic out_item_t next_result(in_item_t it);
    out_item_t o;
    o = '0;
    case (it.mode)
      MODE_LOAD:     graph_rows[it.row_index] = it.row_bits;
      MODE_CLASSIFY: o.verdict = classify_graph();
      MODE_BUILD:    build_circuit(it.start_vertex);
      default: begin
        if (read_pos < walk_len) begin
          o.vertex = walk_list[read_pos];
          o.last = (read_pos + 1 == walk_len);
          read_pos++;
        end else begin
          o.none_left = 1'b1;
        end
      end
    endcase
    o.circuit_length = walk_len[LEN_W-1:0];
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    if (fails < 40)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) graph_rows[i] = '0;
      walk_len = 0;
      read_pos = 0;
      vcount = 6'd32;
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) vcount = cfg_data;
      if (in_valid && !in_stall) awaited.insert(awaited.size(), next_result(in_data));
      if (out_valid && !out_stall) begin
        seen++;
        if (awaited.size() == 0) begin
          report("unexpected result", out_data.vertex, -1);
        end else begin
          want = awaited.pop_front();
          if (out_data.verdict != want.verdict)
            report("verdict", out_data.verdict, want.verdict);
          if (out_data.vertex != want.vertex)
            report("vertex", out_data.vertex, want.vertex);
          if (out_data.circuit_length != want.circuit_length)
            report("circuit_length", out_data.circuit_length, want.circuit_length);
          if (out_data.last != want.last)
            report("last", out_data.last, want.last);
          if (out_data.none_left != want.none_left)
            report("none_left", out_data.none_left, want.none_left);
        end
      end
    end
    fail_count <= fails;
    pending    <= awaited.size();
    checked    <= seen;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the Euler circuit engine with directed corner cases and then with
// random graph sessions (load, classify, build, read back) under varying
// sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import dece_pkg::*;

  localparam int TARGET_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 1000000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_data = '0;

  int fail_count, pending, checked;
  int sent = 0;
  int cycles = 0;
  int tx_idle = 0;   // percent of cycles the sender holds back
  int rx_idle = 0;   // percent of cycles the receiver stalls

  always #1 clk = ~clk;

  directed_euler_circuit_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  dece_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < rx_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("directed_euler_circuit_engine test failed");
      $finish;
    end
  end

  // idling profile follows progress: sender light / receiver heavy,
  // then swapped, then full speed
  task automatic send_item(logic [1:0] mode, logic [4:0] row, logic [31:0] bits,
                           logic [4:0] origin);
    int gap;
    in_item_t it;
    if (sent < TARGET_ITEMS / 3) begin
      tx_idle = 17; rx_idle = 84;
    end else if (sent < 2 * TARGET_ITEMS / 3) begin
      tx_idle = 84; rx_idle = 17;
    end else begin
      tx_idle = 0; rx_idle = 0;
    end
    gap = 0;
    while ($urandom_range(99) < tx_idle && gap < 50) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.mode = mode;
    it.row_index = row;
    it.row_bits = bits;
    it.start_vertex = origin;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // let every outstanding result come back, plus a margin for the engine
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_vcount(logic [5:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic read_back(int count);
    repeat (count) send_item(MODE_READ, 5'($urandom), $urandom, 5'($urandom));
  endtask

  // one graph session: set the vertex count, load a graph, classify,
  // build and read part or all of the circuit back
  task automatic graph_session();
    logic [5:0]  raw;
    logic [31:0] g [32];
    logic [31:0] m;
    int order [32];
    int en, kind, k, j, t, drop_a, drop_b, edges, pick;
    logic [4:0] origin;
    pick = $urandom_range(99);
    if (pick < 75) raw = 6'($urandom_range(2, 8));
    else if (pick < 92) raw = 6'($urandom_range(9, 31));
    else begin
      case ($urandom_range(3))
        0: raw = 6'd0;
        1: raw = 6'd32;
        2: raw = 6'($urandom_range(33, 63));
        default: raw = 6'd1;
      endcase
    end
    en = (raw == 0) ? 1 : (raw > 32) ? 32 : raw;
    m = (en >= 32) ? '1 : (32'd1 << en) - 1;
    write_vcount(raw);

    for (int i = 0; i < 32; i++) g[i] = '0;
    drop_a = 0; drop_b = 0;
    kind = $urandom_range(9);
    if (kind < 6) begin
      // unions of simple cycles give circuits; dropping an edge gives a path
      repeat ($urandom_range(1, 2)) begin
        for (int i = 0; i < en; i++) order[i] = i;
        for (int i = en - 1; i > 0; i--) begin
          j = $urandom_range(i);
          t = order[i]; order[i] = order[j]; order[j] = t;
        end
        k = $urandom_range(1, en);
        for (int i = 0; i < k; i++) g[order[i]][order[(i + 1) % k]] = 1'b1;
        drop_a = order[0];
        drop_b = order[1 % k];
      end
      if (kind >= 4) g[drop_a][drop_b] = 1'b0;
    end else if (kind < 9) begin
      for (int i = 0; i < en; i++) g[i] = $urandom & $urandom & m;
    end

    for (int i = 0; i < en; i++) begin
      send_item(MODE_LOAD, 5'(i), g[i], 5'($urandom));
      if ($urandom_range(19) == 0)
        send_item(2'($urandom_range(3)), 5'($urandom), $urandom, 5'($urandom));
    end
    // rows above the vertex count are stored but must be ignored
    if (en < 32 && $urandom_range(2) == 0)
      send_item(MODE_LOAD, 5'($urandom_range(en, 31)), $urandom, 5'($urandom));

    send_item(MODE_CLASSIFY, 5'($urandom), $urandom, 5'($urandom));
    origin = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'(drop_a);
    send_item(MODE_BUILD, 5'($urandom), $urandom, origin);
    edges = 0;
    for (int i = 0; i < en; i++) edges += $countones(g[i] & m);
    read_back((edges + 3 > 40) ? $urandom_range(1, 40) : $urandom_range(1, edges + 3));
    if ($urandom_range(3) == 0) begin
      send_item(MODE_CLASSIFY, 5'($urandom), $urandom, 5'($urandom));
      send_item(MODE_BUILD, 5'($urandom), $urandom, 5'($urandom_range(en - 1)));
      read_back($urandom_range(1, 4));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty engine: nothing stored, empty graph is a circuit,
    // build on an edgeless vertex gives that vertex alone
    send_item(MODE_READ, 5'd0, 32'd0, 5'd0);
    send_item(MODE_CLASSIFY, 5'd31, '1, 5'd31);
    send_item(MODE_BUILD, 5'd0, 32'd0, 5'd5);
    read_back(2);

    // count of zero acts as one vertex; the row of vertex 31 is kept but ignored
    write_vcount(6'd0);
    send_item(MODE_LOAD, 5'd0, '1, 5'd0);
    send_item(MODE_LOAD, 5'd31, '1, 5'd0);
    send_item(MODE_CLASSIFY, 5'd0, 32'd0, 5'd0);
    send_item(MODE_BUILD, 5'd0, 32'd0, 5'd31);
    send_item(MODE_BUILD, 5'd0, 32'd0, 5'd0);
    read_back(3);

    // count above the limit acts as 32: loop 31 -> 0 -> 31 plus a self loop
    write_vcount(6'd63);
    send_item(MODE_LOAD, 5'd31, 32'h8000_0001, 5'd0);
    send_item(MODE_LOAD, 5'd0, 32'h8000_0000, 5'd0);
    send_item(MODE_CLASSIFY, 5'd0, 32'd0, 5'd0);
    send_item(MODE_BUILD, 5'd0, 32'd0, 5'd31);
    read_back(4);
    // dropping edge 0 -> 31 leaves an Euler path
    send_item(MODE_LOAD, 5'd0, 32'd0, 5'd0);
    send_item(MODE_CLASSIFY, 5'd0, 32'd0, 5'd0);

    // complete graph on 32 vertices: longest possible circuit
    write_vcount(6'd32);
    for (int i = 0; i < 32; i++) send_item(MODE_LOAD, 5'(i), '1, 5'd0);
    send_item(MODE_CLASSIFY, 5'd0, 32'd0, 5'd0);
    send_item(MODE_BUILD, 5'd0, 32'd0, 5'd7);
    read_back(30);
    write_vcount(6'd1);

    while (sent < TARGET_ITEMS) graph_session();

    drain();
    repeat (20) @(posedge clk);
    $display("%0d items sent, %0d results checked over random graphs of 1 to 32 vertices,",
             sent, checked);
    $display("with out-of-range vertex counts and three idling profiles");
    if (fail_count == 0) begin
      $display("directed_euler_circuit_engine test passed");
    end else begin
      $display("directed_euler_circuit_engine test failed");
    end
    $finish;
  end

endmodule
